// ===== hdl/p2md_pkg.sv =====
// ----------------------------------------------------------------------------
// p2md_pkg
// Shared types and constants for the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
package p2md_pkg;

   // field widths
   localparam int unsigned ByteW   = 8;
   localparam int unsigned BtnW    = 3;
   localparam int unsigned MoveXW  = 9;
   localparam int unsigned MoveYW  = 10;
   localparam int unsigned PosW    = 12;
   localparam int unsigned CsrIdxW = 1;
   localparam int unsigned CsrDatW = 12;

   // protocol constants
   localparam logic [ByteW-1:0] AckByte   = 8'hFA;
   localparam logic [ByteW-1:0] SyncMask  = 8'hC8;
   localparam logic [ByteW-1:0] SyncMatch = 8'h08;

   // status byte bit positions
   localparam int unsigned XSignBit = 4;
   localparam int unsigned YSignBit = 5;

   // register reset values
   localparam logic [PosW-1:0] WidthReset  = 12'd640;
   localparam logic [PosW-1:0] HeightReset = 12'd480;

   // register indexes
   typedef enum logic [CsrIdxW-1:0] {
      REG_SCREEN_WIDTH  = 1'b0,
      REG_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   // packet phase
   typedef enum logic [1:0] {
      PH_WAIT_ACK    = 2'd0,
      PH_WAIT_STATUS = 2'd1,
      PH_WAIT_X      = 2'd2,
      PH_WAIT_Y      = 2'd3
   } phase_type;

   // add a movement to a position and clamp to [0, bound]
   function automatic logic [PosW-1:0] clamp_pos(input logic [PosW-1:0] pos,
                                                 input logic signed [MoveYW-1:0] delta,
                                                 input logic [PosW-1:0] bound);
      logic signed [PosW+1:0] sum;
      logic signed [PosW+1:0] lim;
      logic [PosW-1:0]        res;
      sum = $signed({2'b00, pos}) + (PosW+2)'(delta);
      lim = $signed({2'b00, bound});
      if (sum < 0) begin
         res = '0;
      end else if (sum >= lim) begin
         res = bound;
      end else begin
         res = sum[PosW-1:0];
      end
      return res;
   endfunction

endpackage

// ===== hdl/p2md_if.sv =====
// ----------------------------------------------------------------------------
// p2md channel interfaces
// Valid/ready channels for received bytes and decoded results.
// ----------------------------------------------------------------------------
interface p2md_req_if
   import p2md_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface p2md_rsp_if
   import p2md_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic                     packet_done;
   logic [BtnW-1:0]          buttons;
   logic signed [MoveXW-1:0] move_x;
   logic signed [MoveYW-1:0] move_y;
   logic [PosW-1:0]          cursor_x;
   logic [PosW-1:0]          cursor_y;

   modport source (output valid, output packet_done, output buttons, output move_x,
                   output move_y, output cursor_x, output cursor_y, input ready);
   modport sink   (input valid, input packet_done, input buttons, input move_x,
                   input move_y, input cursor_x, input cursor_y, output ready);
endinterface

// ===== hdl/ps2_mouse_packet_decoder.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder
// Decodes three-byte PS/2 mouse packets and tracks a clamped cursor position.
// ----------------------------------------------------------------------------
// The result is registered and is valid in the cycle after the byte transfer.
// Throughput: one byte per cycle; the result register is refilled in the
// cycle it is taken, so the rate is set only by the result side stalling.
// Reset: synchronous; waits for the acknowledge byte, cursor at 0,0,
// screen bounds back to 640 x 480.
module ps2_mouse_packet_decoder
   import p2md_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   p2md_req_if.sink            req_if,
   p2md_rsp_if.source          rsp_if,
   input  logic                csr_write_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDatW-1:0]  csr_write_data
);

   phase_type          phase_ff, phase_in;
   logic [ByteW-1:0]   status_ff, status_in;
   logic [ByteW-1:0]   xbyte_ff, xbyte_in;
   logic [PosW-1:0]    pos_x_ff, pos_x_in;
   logic [PosW-1:0]    pos_y_ff, pos_y_in;
   logic [PosW-1:0]    width_ff, height_ff;

   logic                     out_valid_ff;
   logic                     done_ff, done_in;
   logic [BtnW-1:0]          btn_ff, btn_in;
   logic signed [MoveXW-1:0] mx_ff, mx_in;
   logic signed [MoveYW-1:0] my_ff, my_in;

   logic                     accept;
   logic signed [MoveXW-1:0] dx;
   logic signed [MoveXW-1:0] dy_raw;
   logic signed [MoveYW-1:0] dy;

   // room when the result register is empty or being drained
   assign req_if.ready = !out_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   // sign-extended movements, y negated
   assign dx     = $signed({status_ff[XSignBit], xbyte_ff});
   assign dy_raw = $signed({status_ff[YSignBit], req_if.rx_byte});
   assign dy     = -(MoveYW'(dy_raw));

   // packet framing and cursor update
   always_comb begin
      phase_in  = phase_ff;
      status_in = status_ff;
      xbyte_in  = xbyte_ff;
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      done_in   = 1'b0;
      btn_in    = '0;
      mx_in     = '0;
      my_in     = '0;
      unique case (phase_ff)
         PH_WAIT_ACK: begin
            if (req_if.rx_byte == AckByte) begin
               phase_in = PH_WAIT_STATUS;
            end
         end
         PH_WAIT_STATUS: begin
            if ((req_if.rx_byte & SyncMask) == SyncMatch) begin
               status_in = req_if.rx_byte;
               phase_in  = PH_WAIT_X;
            end
         end
         PH_WAIT_X: begin
            xbyte_in = req_if.rx_byte;
            phase_in = PH_WAIT_Y;
         end
         PH_WAIT_Y: begin
            done_in  = 1'b1;
            btn_in   = status_ff[BtnW-1:0];
            mx_in    = dx;
            my_in    = dy;
            pos_x_in = clamp_pos(pos_x_ff, MoveYW'(dx), width_ff);
            pos_y_in = clamp_pos(pos_y_ff, dy, height_ff);
            phase_in = PH_WAIT_STATUS;
         end
         default: begin
            phase_in = PH_WAIT_ACK;
         end
      endcase
   end

   // decoder state, updated on each byte transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT_ACK;
         status_ff <= '0;
         xbyte_ff  <= '0;
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         status_ff <= status_in;
         xbyte_ff  <= xbyte_in;
         pos_x_ff  <= pos_x_in;
         pos_y_ff  <= pos_y_in;
      end
   end

   // screen bound registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WidthReset;
         height_ff <= HeightReset;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            REG_SCREEN_WIDTH:  width_ff  <= csr_write_data[PosW-1:0];
            REG_SCREEN_HEIGHT: height_ff <= csr_write_data[PosW-1:0];
            default: ;
         endcase
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         done_ff <= done_in;
         btn_ff  <= btn_in;
         mx_ff   <= mx_in;
         my_ff   <= my_in;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.packet_done = done_ff;
   assign rsp_if.buttons     = btn_ff;
   assign rsp_if.move_x      = mx_ff;
   assign rsp_if.move_y      = my_ff;
   // position registers change only on transfer, which also reloads the result
   assign rsp_if.cursor_x    = pos_x_ff;
   assign rsp_if.cursor_y    = pos_y_ff;

endmodule
